@@ hw/rtl/qcc_pkg.sv @@
package qcc_pkg;

    // Field widths
    localparam int unsigned FW   = 32;   // input and point fields, Q16.16
    localparam int unsigned CW   = 48;   // cost field, Q32.16

    // Internal arithmetic widths
    localparam int unsigned MW   = 64;   // adjugate entries and 32x32 products
    localparam int unsigned PW   = 97;   // one 64x32 product
    localparam int unsigned DTW  = 99;   // determinant and point numerators
    localparam int unsigned DW   = 131;  // divider dividend and shifted divisor
    localparam int unsigned AW   = 101;  // cost accumulator at 2^-48
    localparam int unsigned SHW  = AW - 32;

    localparam int unsigned DIV_BITS   = 32;
    localparam int unsigned NUM_STAGES = 14 + DIV_BITS;

    localparam logic signed [SHW-1:0] COST_HI = 69'sh7FFF_FFFF_FFFF;
    localparam logic signed [SHW-1:0] COST_LO = -69'sh8000_0000_0000;

    typedef struct packed {
        logic signed [FW-1:0] a_xx;
        logic signed [FW-1:0] a_xy;
        logic signed [FW-1:0] a_xz;
        logic signed [FW-1:0] a_yy;
        logic signed [FW-1:0] a_yz;
        logic signed [FW-1:0] a_zz;
        logic signed [FW-1:0] b_x;
        logic signed [FW-1:0] b_y;
        logic signed [FW-1:0] b_z;
        logic signed [FW-1:0] c_term;
    } quad_word_t;

    typedef struct packed {
        logic signed [FW-1:0] pos_x;
        logic signed [FW-1:0] pos_y;
        logic signed [FW-1:0] pos_z;
        logic signed [CW-1:0] err_cost;
        logic                 singular;
    } result_word_t;

endpackage

@@ hw/rtl/qcc_quad_if.sv @@
interface qcc_quad_if import qcc_pkg::*; ();
    logic       valid;
    logic       ready;
    quad_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/qcc_result_if.sv @@
interface qcc_result_if import qcc_pkg::*; ();
    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/quadric_collapse_point_and_cost_unit.sv @@
// Quadric collapse point and cost unit. Each word on quad carries one edge quadric
// (symmetric A, vector b, scalar c, all signed Q16.16); each word on result carries the
// optimal point v = -A^-1 b (Q16.16, rounded to nearest with ties away from zero,
// saturated), the error v.Av + 2b.v + c (Q32.16, rounded half up, saturated) and a
// singular flag that zeroes all other fields when det(A) is zero. The unit takes one
// word per cycle, unless the full output queue stalls the pipeline, and returns words
// in order. The pipeline holds the point divider, which resolves one quotient bit per
// stage over 32 stages, plus seven stages ahead of it for the adjugate and determinant
// and seven after it for the cost. A two-word output queue decouples the pipeline from
// result.ready, so words keep entering while finished results wait.
module quadric_collapse_point_and_cost_unit import qcc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    qcc_quad_if.sink     quad,
    qcc_result_if.source result
);

    typedef struct packed {
        logic [2:0][DW-1:0]       rem;
        logic [2:0][DIV_BITS-1:0] quo;
        logic [2:0]               sat;
        logic [2:0]               neg;
        logic [DW-1:0]            den;
        logic                     sing;
        quad_word_t               qd;
    } div_word_t;

    // Pipeline control: one global advance, stalled only when the last stage holds
    // a word that the full output queue cannot take.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [1:0]            fifo_cnt_reg;
    logic                  adv;
    logic                  push;
    logic                  pop;

    assign adv        = !vld_reg[NUM_STAGES-1] || (fifo_cnt_reg != 2'd2);
    assign push       = vld_reg[NUM_STAGES-1] && (fifo_cnt_reg != 2'd2);
    assign pop        = (fifo_cnt_reg != 2'd0) && result.ready;
    assign quad.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], quad.valid};
        end
    end

    // Stage 0: the twelve 32x32 products of the adjugate
    logic signed [MW-1:0] pr_next [12];
    logic signed [MW-1:0] s0_pr_reg [12];
    quad_word_t           s0_qd_reg;

    always_comb
    begin
        pr_next[0]  = quad.data.a_yy * quad.data.a_zz;
        pr_next[1]  = quad.data.a_yz * quad.data.a_yz;
        pr_next[2]  = quad.data.a_xz * quad.data.a_yz;
        pr_next[3]  = quad.data.a_xy * quad.data.a_zz;
        pr_next[4]  = quad.data.a_xy * quad.data.a_yz;
        pr_next[5]  = quad.data.a_xz * quad.data.a_yy;
        pr_next[6]  = quad.data.a_xx * quad.data.a_zz;
        pr_next[7]  = quad.data.a_xz * quad.data.a_xz;
        pr_next[8]  = quad.data.a_xy * quad.data.a_xz;
        pr_next[9]  = quad.data.a_xx * quad.data.a_yz;
        pr_next[10] = quad.data.a_xx * quad.data.a_yy;
        pr_next[11] = quad.data.a_xy * quad.data.a_xy;
    end

    // Stage 1: adjugate, order xx, xy, xz, yy, yz, zz
    logic signed [MW-1:0] s1_adj_reg [6];
    quad_word_t           s1_qd_reg;

    // Stage 2: split each 64x32 product into two partial products over the 32-bit halves of the adjugate entry.
    // Products 0..2 form the determinant, 3..11 the three point numerators.
    logic signed [MW-1:0]   mul_adj [12];
    logic signed [FW-1:0]   mul_x [12];
    logic signed [MW-1:0]   ph_next [12];
    logic signed [MW:0]     pl_next [12];
    logic signed [MW-1:0]   s2_ph_reg [12];
    logic signed [MW:0]     s2_pl_reg [12];
    quad_word_t             s2_qd_reg;

    always_comb
    begin
        logic signed [FW-1:0] hi;
        logic signed [FW:0]   lo;
        mul_adj[0]  = s1_adj_reg[0]; mul_x[0]  = s1_qd_reg.a_xx;
        mul_adj[1]  = s1_adj_reg[1]; mul_x[1]  = s1_qd_reg.a_xy;
        mul_adj[2]  = s1_adj_reg[2]; mul_x[2]  = s1_qd_reg.a_xz;
        mul_adj[3]  = s1_adj_reg[0]; mul_x[3]  = s1_qd_reg.b_x;
        mul_adj[4]  = s1_adj_reg[1]; mul_x[4]  = s1_qd_reg.b_y;
        mul_adj[5]  = s1_adj_reg[2]; mul_x[5]  = s1_qd_reg.b_z;
        mul_adj[6]  = s1_adj_reg[1]; mul_x[6]  = s1_qd_reg.b_x;
        mul_adj[7]  = s1_adj_reg[3]; mul_x[7]  = s1_qd_reg.b_y;
        mul_adj[8]  = s1_adj_reg[4]; mul_x[8]  = s1_qd_reg.b_z;
        mul_adj[9]  = s1_adj_reg[2]; mul_x[9]  = s1_qd_reg.b_x;
        mul_adj[10] = s1_adj_reg[4]; mul_x[10] = s1_qd_reg.b_y;
        mul_adj[11] = s1_adj_reg[5]; mul_x[11] = s1_qd_reg.b_z;
        for (int i = 0; i < 12; i++)
        begin
            hi         = mul_adj[i][MW-1:FW];
            lo         = {1'b0, mul_adj[i][FW-1:0]};
            ph_next[i] = hi * mul_x[i];
            pl_next[i] = lo * mul_x[i];
        end
    end

    // Stage 3: full products
    logic signed [PW-1:0] s3_full_reg [12];
    quad_word_t           s3_qd_reg;

    // Stage 4: determinant and numerators
    logic signed [DTW-1:0] s4_det_reg;
    logic signed [DTW-1:0] s4_num_reg [3];
    quad_word_t            s4_qd_reg;

    // Stage 5: magnitudes, dividend (|num| << 17) + |det| and divisor 2|det|
    logic [DTW-1:0]  det_mag;
    logic [2:0]      neg_next;
    logic [DW-1:0]   top_next [3];
    logic [DW-1:0]   s5_top_reg [3];
    logic [DW-1:0]   s5_den_reg;
    logic [2:0]      s5_neg_reg;
    logic            s5_sing_reg;
    quad_word_t      s5_qd_reg;

    always_comb
    begin
        logic [DTW-1:0] num_mag;
        det_mag = s4_det_reg[DTW-1] ? DTW'(-s4_det_reg) : DTW'(s4_det_reg);
        for (int i = 0; i < 3; i++)
        begin
            num_mag     = s4_num_reg[i][DTW-1] ? DTW'(-s4_num_reg[i]) : DTW'(s4_num_reg[i]);
            neg_next[i] = (s4_num_reg[i][DTW-1] == s4_det_reg[DTW-1]);
            top_next[i] = (DW'(num_mag) << 17) + DW'(det_mag);
        end
    end

    // Stage 6 and the divider: div_reg[0] holds the saturation check, div_reg[k+1]
    // holds quotient bits resolved down to bit DIV_BITS-1-k.
    div_word_t div_reg [DIV_BITS+1];
    div_word_t div_next [DIV_BITS+1];

    always_comb
    begin
        logic [DW-1:0] sub;
        div_next[0].den  = s5_den_reg;
        div_next[0].neg  = s5_neg_reg;
        div_next[0].sing = s5_sing_reg;
        div_next[0].qd   = s5_qd_reg;
        for (int i = 0; i < 3; i++)
        begin
            div_next[0].rem[i] = s5_top_reg[i];
            div_next[0].quo[i] = '0;
            div_next[0].sat[i] = s5_top_reg[i] >= (s5_den_reg << DIV_BITS);
        end
        for (int k = 0; k < DIV_BITS; k++)
        begin
            div_next[k+1] = div_reg[k];
            sub           = div_reg[k].den << (DIV_BITS - 1 - k);
            for (int i = 0; i < 3; i++)
            begin
                if (div_reg[k].rem[i] >= sub)
                begin
                    div_next[k+1].rem[i]                  = div_reg[k].rem[i] - sub;
                    div_next[k+1].quo[i][DIV_BITS-1-k]    = 1'b1;
                end
            end
        end
    end

    // Coordinate stage: round already folded into the dividend; clamp and sign, zero if singular
    div_word_t              dv_last;
    logic signed [FW-1:0]   v_next [3];
    logic signed [FW-1:0]   s39_v_reg [3];
    logic                   s39_sing_reg;
    quad_word_t             s39_qd_reg;

    assign dv_last = div_reg[DIV_BITS];

    always_comb
    begin
        logic [FW-1:0] lim;
        logic [FW-1:0] mag;
        for (int i = 0; i < 3; i++)
        begin
            lim = dv_last.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            mag = (dv_last.sat[i] || (dv_last.quo[i] > lim)) ? lim : dv_last.quo[i];
            if (dv_last.sing)
            begin
                v_next[i] = '0;
            end
            else
            begin
                v_next[i] = dv_last.neg[i] ? FW'(-mag) : FW'(mag);
            end
        end
    end

    // Cost stage 1: A entries times v, b times v. Off-diagonal terms count twice.
    // Order: xx*v0, yy*v1, zz*v2, xy*v0, xz*v0, yz*v1.
    logic signed [MW-1:0] t_next [6];
    logic signed [MW-1:0] bv_next [3];
    logic signed [MW-1:0] c1_t_reg [6];
    logic signed [FW-1:0] c1_w_reg [6];
    logic signed [MW-1:0] c1_bv_reg [3];
    logic signed [FW-1:0] c1_c_reg;
    logic signed [FW-1:0] c1_v_reg [3];
    logic                 c1_sing_reg;

    always_comb
    begin
        t_next[0]  = s39_qd_reg.a_xx * s39_v_reg[0];
        t_next[1]  = s39_qd_reg.a_yy * s39_v_reg[1];
        t_next[2]  = s39_qd_reg.a_zz * s39_v_reg[2];
        t_next[3]  = s39_qd_reg.a_xy * s39_v_reg[0];
        t_next[4]  = s39_qd_reg.a_xz * s39_v_reg[0];
        t_next[5]  = s39_qd_reg.a_yz * s39_v_reg[1];
        bv_next[0] = s39_qd_reg.b_x * s39_v_reg[0];
        bv_next[1] = s39_qd_reg.b_y * s39_v_reg[1];
        bv_next[2] = s39_qd_reg.b_z * s39_v_reg[2];
    end

    // Cost stage 2: partial products of t times the second coordinate
    logic signed [MW-1:0] cph_next [6];
    logic signed [MW:0]   cpl_next [6];
    logic signed [MW-1:0] c2_ph_reg [6];
    logic signed [MW:0]   c2_pl_reg [6];
    logic signed [MW-1:0] c2_bv_reg [3];
    logic signed [FW-1:0] c2_c_reg;
    logic signed [FW-1:0] c2_v_reg [3];
    logic                 c2_sing_reg;

    always_comb
    begin
        logic signed [FW-1:0] hi;
        logic signed [FW:0]   lo;
        for (int i = 0; i < 6; i++)
        begin
            hi          = c1_t_reg[i][MW-1:FW];
            lo          = {1'b0, c1_t_reg[i][FW-1:0]};
            cph_next[i] = hi * c1_w_reg[i];
            cpl_next[i] = lo * c1_w_reg[i];
        end
    end

    // Cost stage 3: full quadratic terms
    logic signed [PW-1:0] c3_full_reg [6];
    logic signed [MW-1:0] c3_bv_reg [3];
    logic signed [FW-1:0] c3_c_reg;
    logic signed [FW-1:0] c3_v_reg [3];
    logic                 c3_sing_reg;

    // Cost stage 4: quadratic and linear partial sums, with the rounding half
    logic signed [AW-1:0] c4_quad_reg;
    logic signed [AW-1:0] c4_lin_reg;
    logic signed [FW-1:0] c4_v_reg [3];
    logic                 c4_sing_reg;

    // Cost stage 5: accumulator at 2^-48
    logic signed [AW-1:0] c5_acc_reg;
    logic signed [FW-1:0] c5_v_reg [3];
    logic                 c5_sing_reg;

    // Cost stage 6: floor to 2^-16 and clamp
    logic signed [SHW-1:0] cost_sh;
    logic signed [CW-1:0]  cost_next;
    result_word_t          out_reg;

    always_comb
    begin
        cost_sh = SHW'(c5_acc_reg >>> 32);
        if (c5_sing_reg)
        begin
            cost_next = '0;
        end
        else if (cost_sh > COST_HI)
        begin
            cost_next = COST_HI[CW-1:0];
        end
        else if (cost_sh < COST_LO)
        begin
            cost_next = COST_LO[CW-1:0];
        end
        else
        begin
            cost_next = cost_sh[CW-1:0];
        end
    end

    // Datapath registers: no reset, advance with the pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_pr_reg <= pr_next;
            s0_qd_reg <= quad.data;

            s1_adj_reg[0] <= s0_pr_reg[0] - s0_pr_reg[1];
            s1_adj_reg[1] <= s0_pr_reg[2] - s0_pr_reg[3];
            s1_adj_reg[2] <= s0_pr_reg[4] - s0_pr_reg[5];
            s1_adj_reg[3] <= s0_pr_reg[6] - s0_pr_reg[7];
            s1_adj_reg[4] <= s0_pr_reg[8] - s0_pr_reg[9];
            s1_adj_reg[5] <= s0_pr_reg[10] - s0_pr_reg[11];
            s1_qd_reg     <= s0_qd_reg;

            s2_ph_reg <= ph_next;
            s2_pl_reg <= pl_next;
            s2_qd_reg <= s1_qd_reg;

            for (int i = 0; i < 12; i++)
            begin
                s3_full_reg[i] <= (PW'(s2_ph_reg[i]) <<< 32) + PW'(s2_pl_reg[i]);
            end
            s3_qd_reg <= s2_qd_reg;

            s4_det_reg <= DTW'(s3_full_reg[0]) + DTW'(s3_full_reg[1]) + DTW'(s3_full_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                s4_num_reg[i] <= DTW'(s3_full_reg[3*i+3]) + DTW'(s3_full_reg[3*i+4])
                               + DTW'(s3_full_reg[3*i+5]);
            end
            s4_qd_reg <= s3_qd_reg;

            s5_top_reg  <= top_next;
            s5_den_reg  <= DW'(det_mag) << 1;
            s5_neg_reg  <= neg_next;
            s5_sing_reg <= (s4_det_reg == '0);
            s5_qd_reg   <= s4_qd_reg;

            div_reg <= div_next;

            s39_v_reg    <= v_next;
            s39_sing_reg <= dv_last.sing;
            s39_qd_reg   <= dv_last.qd;

            c1_t_reg    <= t_next;
            c1_w_reg[0] <= s39_v_reg[0];
            c1_w_reg[1] <= s39_v_reg[1];
            c1_w_reg[2] <= s39_v_reg[2];
            c1_w_reg[3] <= s39_v_reg[1];
            c1_w_reg[4] <= s39_v_reg[2];
            c1_w_reg[5] <= s39_v_reg[2];
            c1_bv_reg   <= bv_next;
            c1_c_reg    <= s39_qd_reg.c_term;
            c1_v_reg    <= s39_v_reg;
            c1_sing_reg <= s39_sing_reg;

            c2_ph_reg   <= cph_next;
            c2_pl_reg   <= cpl_next;
            c2_bv_reg   <= c1_bv_reg;
            c2_c_reg    <= c1_c_reg;
            c2_v_reg    <= c1_v_reg;
            c2_sing_reg <= c1_sing_reg;

            for (int i = 0; i < 6; i++)
            begin
                c3_full_reg[i] <= (PW'(c2_ph_reg[i]) <<< 32) + PW'(c2_pl_reg[i]);
            end
            c3_bv_reg   <= c2_bv_reg;
            c3_c_reg    <= c2_c_reg;
            c3_v_reg    <= c2_v_reg;
            c3_sing_reg <= c2_sing_reg;

            c4_quad_reg <= AW'(c3_full_reg[0]) + AW'(c3_full_reg[1]) + AW'(c3_full_reg[2])
                         + ((AW'(c3_full_reg[3]) + AW'(c3_full_reg[4])
                           + AW'(c3_full_reg[5])) <<< 1);
            c4_lin_reg  <= ((AW'(c3_bv_reg[0]) + AW'(c3_bv_reg[1]) + AW'(c3_bv_reg[2])) <<< 17)
                         + (AW'(c3_c_reg) <<< 32) + (AW'(1) <<< 31);
            c4_v_reg    <= c3_v_reg;
            c4_sing_reg <= c3_sing_reg;

            c5_acc_reg  <= c4_quad_reg + c4_lin_reg;
            c5_v_reg    <= c4_v_reg;
            c5_sing_reg <= c4_sing_reg;

            out_reg.pos_x    <= c5_v_reg[0];
            out_reg.pos_y    <= c5_v_reg[1];
            out_reg.pos_z    <= c5_v_reg[2];
            out_reg.err_cost <= cost_next;
            out_reg.singular <= c5_sing_reg;
        end
    end

    // Output queue: two words, hold results while result.ready is low
    result_word_t fifo_mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            fifo_cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fifo_cnt_reg <= fifo_cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fifo_cnt_reg <= fifo_cnt_reg - 2'd1;
            end
        end
    end

    assign result.valid = (fifo_cnt_reg != 2'd0);
    assign result.data  = fifo_mem_reg[rd_ptr_reg];

endmodule
